FILE: src/sbc_pkg.sv
// Shared constants, types and command/status structs for the sort-and-count block.
`default_nettype none
package sbc_pkg;

    localparam int ITEM_COUNT = 16;
    localparam int IDX_W      = $clog2(ITEM_COUNT);
    localparam int FILL_W     = $clog2(ITEM_COUNT + 1);
    localparam int QUARTER_LO = ITEM_COUNT - ITEM_COUNT / 4;
    localparam int HALF_LO    = ITEM_COUNT / 2;

    localparam int VALUE_W    = 16;
    localparam int RANK_W     = 4;
    localparam int QUARTER_W  = 3;
    localparam int BAND_W     = 5;
    localparam int OUT_W      = VALUE_W + RANK_W + QUARTER_W + BAND_W;
    localparam int TDATA_W    = ((OUT_W + 7) / 8) * 8;

    localparam int QUARTER_MAX = 7;
    localparam int BAND_MAX    = 15;
    localparam int BAND_MIN    = -16;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic signed [VALUE_W-1:0] HIGH_RESET = 16'sd85;
    localparam logic signed [VALUE_W-1:0] MID_RESET  = 16'sd75;

    // Register select is paddr[2]: word 0 and word 1.
    localparam logic REG_HIGH = 1'b0;
    localparam logic REG_MID  = 1'b1;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_COUNT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic insert;
        logic count;
        logic emit;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic last_load;
        logic last_rank;
    } status_t;

endpackage
`default_nettype wire

FILE: src/sort16_with_band_counts_core.sv
// Top level: configuration registers and the controller/datapath pair.
//
// Usage: sixteen signed 16-bit values enter on the slave stream, one item each.
// After the sixteenth the block emits sixteen result items on the master stream in
// ascending order. Each carries the value, its rank and two counts over the run:
// how many of the top quarter are at or above high_threshold, and how many of the
// top half are at or above mid_threshold minus that first count. tlast marks rank 15.
// Each loaded item is inserted into a sorted register chain as it is taken, so
// s_tready stays high through the sixteen loads. A count state then registers the
// counts, and results leave at one per cycle from the output register while
// m_tready is high, the first being loaded in the emit state that follows the count
// state. While results are emitted s_tready is low; a stall on m_tready holds the
// output item and pauses emission. Loading of the next run starts as soon as the
// last result sits in the output register, even if it is still stalled there.
// Reset clears the run, drops m_tvalid and sets the thresholds to 85 and 75.
// Thresholds are written through the APB port at addresses 0 and 4; the user must
// write them only while idle, and the block itself does not enforce it.
`default_nettype none
module sort16_with_band_counts_core
(
    input  wire                                clk,
    input  wire                                rst_n,
    // s_tdata: [15:0] sample_value
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire  [sbc_pkg::VALUE_W-1:0]        s_tdata,
    // m_tdata: [15:0] sorted_value, [19:16] rank, [22:20] top_quarter_count,
    //          [27:23] band_count, [31:28] zero
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [sbc_pkg::TDATA_W-1:0]        m_tdata,
    output logic                               m_tlast,
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire  [sbc_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire  [sbc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [sbc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);

    logic signed [sbc_pkg::VALUE_W-1:0] high_threshold_reg;
    logic signed [sbc_pkg::VALUE_W-1:0] mid_threshold_reg;
    logic                               cfg_write;
    sbc_pkg::cmd_t                      cmd;
    sbc_pkg::status_t                   status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_threshold_reg <= sbc_pkg::HIGH_RESET;
            mid_threshold_reg  <= sbc_pkg::MID_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == sbc_pkg::REG_HIGH)
            begin
                high_threshold_reg <= pwdata[sbc_pkg::VALUE_W-1:0];
            end
            else
            begin
                mid_threshold_reg <= pwdata[sbc_pkg::VALUE_W-1:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == sbc_pkg::REG_MID)
        begin
            prdata = sbc_pkg::APB_DATA_W'(mid_threshold_reg[sbc_pkg::VALUE_W-1:0]);
        end
        else
        begin
            prdata = sbc_pkg::APB_DATA_W'(high_threshold_reg[sbc_pkg::VALUE_W-1:0]);
        end
    end

    sbc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sbc_datapath u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .sample_value   ($signed(s_tdata)),
        .high_threshold (high_threshold_reg),
        .mid_threshold  (mid_threshold_reg),
        .out_data       (m_tdata),
        .out_last       (m_tlast)
    );

endmodule
`default_nettype wire

FILE: src/sbc_datapath.sv
// Datapath: sorted insertion chain, threshold counters and the output register.
`default_nettype none
module sbc_datapath
(
    input  wire                                     clk,
    input  wire                                     rst_n,
    input  wire sbc_pkg::cmd_t                      cmd,
    output sbc_pkg::status_t                        status,
    input  wire logic signed [sbc_pkg::VALUE_W-1:0] sample_value,
    input  wire logic signed [sbc_pkg::VALUE_W-1:0] high_threshold,
    input  wire logic signed [sbc_pkg::VALUE_W-1:0] mid_threshold,
    output logic [sbc_pkg::TDATA_W-1:0]             out_data,
    output logic                                    out_last
);

    logic signed [sbc_pkg::VALUE_W-1:0] cell_reg  [sbc_pkg::ITEM_COUNT];
    logic signed [sbc_pkg::VALUE_W-1:0] cell_next [sbc_pkg::ITEM_COUNT];
    logic [sbc_pkg::ITEM_COUNT-1:0]     greater;

    logic [sbc_pkg::FILL_W-1:0]         fill_reg;
    logic [sbc_pkg::FILL_W-1:0]         fill_next;
    logic [sbc_pkg::IDX_W-1:0]          rank_reg;
    logic [sbc_pkg::IDX_W-1:0]          rank_next;

    logic [sbc_pkg::ITEM_COUNT/4-1:0]   high_hits;
    logic [sbc_pkg::ITEM_COUNT/2-1:0]   mid_hits;
    logic [sbc_pkg::FILL_W-1:0]         quarter_sum;
    logic [sbc_pkg::FILL_W-1:0]         half_sum;
    logic signed [sbc_pkg::FILL_W:0]    band_wide;
    logic [sbc_pkg::QUARTER_W-1:0]      quarter_sat;
    logic signed [sbc_pkg::BAND_W-1:0]  band_sat;

    logic [sbc_pkg::QUARTER_W-1:0]      quarter_reg;
    logic signed [sbc_pkg::BAND_W-1:0]  band_reg;
    logic [sbc_pkg::TDATA_W-1:0]        out_data_reg;
    logic                               out_last_reg;

    // A cell is "greater" when it is empty or holds a larger value; the chain stays
    // ascending, so the first greater cell takes the new item and the rest shift up.
    always_comb
    begin
        for (int k = 0; k < sbc_pkg::ITEM_COUNT; k++)
        begin
            greater[k] = (fill_reg <= sbc_pkg::FILL_W'(k)) || (cell_reg[k] > sample_value);
        end
        cell_next[0] = greater[0] ? sample_value : cell_reg[0];
        for (int k = 1; k < sbc_pkg::ITEM_COUNT; k++)
        begin
            cell_next[k] = cell_reg[k];
            if (greater[k])
            begin
                if (greater[k-1])
                begin
                    cell_next[k] = cell_reg[k-1];
                end
                else
                begin
                    cell_next[k] = sample_value;
                end
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < sbc_pkg::ITEM_COUNT / 4; k++)
        begin
            high_hits[k] = cell_reg[sbc_pkg::QUARTER_LO + k] >= high_threshold;
        end
        for (int k = 0; k < sbc_pkg::ITEM_COUNT / 2; k++)
        begin
            mid_hits[k] = cell_reg[sbc_pkg::HALF_LO + k] >= mid_threshold;
        end
        quarter_sum = sbc_pkg::FILL_W'($countones(high_hits));
        half_sum    = sbc_pkg::FILL_W'($countones(mid_hits));
        band_wide   = $signed({1'b0, half_sum}) - $signed({1'b0, quarter_sum});

        if (quarter_sum > sbc_pkg::FILL_W'(sbc_pkg::QUARTER_MAX))
        begin
            quarter_sat = sbc_pkg::QUARTER_W'(sbc_pkg::QUARTER_MAX);
        end
        else
        begin
            quarter_sat = sbc_pkg::QUARTER_W'(quarter_sum);
        end

        if (band_wide > sbc_pkg::BAND_MAX)
        begin
            band_sat = sbc_pkg::BAND_W'(sbc_pkg::BAND_MAX);
        end
        else if (band_wide < sbc_pkg::BAND_MIN)
        begin
            band_sat = sbc_pkg::BAND_W'(sbc_pkg::BAND_MIN);
        end
        else
        begin
            band_sat = sbc_pkg::BAND_W'(band_wide);
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (cmd.clear)
        begin
            fill_next = '0;
        end
        else if (cmd.insert)
        begin
            fill_next = fill_reg + 1'b1;
        end

        rank_next = rank_reg;
        if (cmd.count)
        begin
            rank_next = '0;
        end
        else if (cmd.emit)
        begin
            rank_next = rank_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            rank_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            rank_reg <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.insert)
        begin
            for (int k = 0; k < sbc_pkg::ITEM_COUNT; k++)
            begin
                cell_reg[k] <= cell_next[k];
            end
        end
        if (cmd.count)
        begin
            quarter_reg <= quarter_sat;
            band_reg    <= band_sat;
        end
        if (cmd.emit)
        begin
            out_data_reg <= sbc_pkg::TDATA_W'({band_reg, quarter_reg,
                                               sbc_pkg::RANK_W'(rank_reg),
                                               cell_reg[rank_reg]});
            out_last_reg <= status.last_rank;
        end
    end

    assign status.last_load = fill_reg == sbc_pkg::FILL_W'(sbc_pkg::ITEM_COUNT - 1);
    assign status.last_rank = rank_reg == sbc_pkg::IDX_W'(sbc_pkg::ITEM_COUNT - 1);
    assign out_data         = out_data_reg;
    assign out_last         = out_last_reg;

endmodule
`default_nettype wire

FILE: src/sbc_ctrl.sv
// Controller: load, count and emit sequencing plus the output valid flag.
`default_nettype none
module sbc_ctrl
(
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  wire                   m_tready,
    input  wire sbc_pkg::status_t status,
    output sbc_pkg::cmd_t         cmd
);

    sbc_pkg::state_t state_reg;
    sbc_pkg::state_t state_next;
    logic            valid_reg;
    logic            valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sbc_pkg::ST_LOAD;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            sbc_pkg::ST_LOAD:
            begin
                s_tready   = 1'b1;
                cmd.insert = s_tvalid;
                if (s_tvalid && status.last_load)
                begin
                    state_next = sbc_pkg::ST_COUNT;
                end
            end
            sbc_pkg::ST_COUNT:
            begin
                cmd.count  = 1'b1;
                state_next = sbc_pkg::ST_EMIT;
            end
            sbc_pkg::ST_EMIT:
            begin
                // The output register is refilled whenever it is empty or being drained.
                if (!valid_reg || m_tready)
                begin
                    cmd.emit = 1'b1;
                    if (status.last_rank)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = sbc_pkg::ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = sbc_pkg::ST_LOAD;
            end
        endcase

        if (cmd.emit)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    assign m_tvalid = valid_reg;

endmodule
`default_nettype wire

FILE: src/sbc_checker.sv
// Port-level assertions for the sort-and-count block, bound to the top level.
`default_nettype none
module sbc_checker
(
    input wire                               clk,
    input wire                               rst_n,
    input wire                               m_tvalid,
    input wire                               m_tready,
    input wire [sbc_pkg::TDATA_W-1:0]        m_tdata,
    input wire                               m_tlast,
    input wire                               pready
);

    // A stalled result item must not change.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result item changed while stalled");

    // The final item of a run is exactly the one of highest rank.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tdata[19:16] == 4'hF)))
        else $error("tlast does not match rank 15");

    // Padding is zero and the quarter count cannot exceed four of sixteen.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[31:28] == 4'h0) && (m_tdata[22:20] <= 3'd4))
        else $error("result item has bad padding or quarter count");

    // Configuration accesses never wait.
    assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind sort16_with_band_counts_core sbc_checker u_sbc_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .pready   (pready)
);
`default_nettype wire

FILE: verif/sort16_with_band_counts_checker.sv
// Result checker for sort-and-count: mirrors the loaded run, compares every result item and APB read.
`timescale 1ns / 1ps
module sort16_with_band_counts_checker
    import sbc_pkg::*;
(
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     s_tvalid,
    input  wire                     s_tready,
    input  wire  [VALUE_W-1:0]      s_tdata,
    input  wire                     m_tvalid,
    input  wire                     m_tready,
    input  wire  [TDATA_W-1:0]      m_tdata,
    input  wire                     m_tlast,
    input  wire                     psel,
    input  wire                     penable,
    input  wire                     pwrite,
    input  wire  [APB_ADDR_W-1:0]   paddr,
    input  wire  [APB_DATA_W-1:0]   pwdata,
    input  wire  [APB_DATA_W-1:0]   prdata,
    input  wire                     pready,
    output int                      failures,
    output int                      pending
);

    typedef struct packed {
        logic [VALUE_W-1:0]   value;
        logic [RANK_W-1:0]    rank;
        logic [QUARTER_W-1:0] top_quarter;
        logic [BAND_W-1:0]    band;
        logic                 last;
    } ranked_value_t;

    logic signed [VALUE_W-1:0] high_thr;
    logic signed [VALUE_W-1:0] mid_thr;
    logic signed [VALUE_W-1:0] run_values [ITEM_COUNT];
    int                        loaded;
    ranked_value_t             ranked_q [$];

    // Sorts the completed run and queues one ranked item per value.
    function automatic void sort_and_count();
        logic signed [VALUE_W-1:0] sorted [ITEM_COUNT];
        logic signed [VALUE_W-1:0] key;
        ranked_value_t             res;
        int                        j;
        int                        quarter;
        int                        half;
        int                        band;
        sorted = run_values;
        for (int i = 1; i < ITEM_COUNT; i++)
        begin
            key = sorted[i];
            j = i - 1;
            while (j >= 0 && sorted[j] > key)
            begin
                sorted[j + 1] = sorted[j];
                j--;
            end
            sorted[j + 1] = key;
        end
        quarter = 0;
        half = 0;
        for (int k = QUARTER_LO; k < ITEM_COUNT; k++)
            if (sorted[k] >= high_thr)
                quarter++;
        for (int k = HALF_LO; k < ITEM_COUNT; k++)
            if (sorted[k] >= mid_thr)
                half++;
        band = half - quarter;
        if (quarter > QUARTER_MAX)
            quarter = QUARTER_MAX;
        if (band > BAND_MAX)
            band = BAND_MAX;
        if (band < BAND_MIN)
            band = BAND_MIN;
        for (int k = 0; k < ITEM_COUNT; k++)
        begin
            res.value       = sorted[k];
            res.rank        = RANK_W'(k);
            res.top_quarter = QUARTER_W'(quarter);
            res.band        = BAND_W'(band);
            res.last        = (k == ITEM_COUNT - 1);
            ranked_q.push_back(res);
        end
    endfunction

    function automatic int check_field(input string field, input int want_v, input int got_v);
        if (want_v != got_v)
        begin
            $error("%s: expected %0d, actual %0d", field, want_v, got_v);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        ranked_value_t want;
        int            errs;
        if (!rst_n)
        begin
            high_thr = HIGH_RESET;
            mid_thr  = MID_RESET;
            loaded   = 0;
            ranked_q.delete();
            failures <= 0;
            pending  <= 0;
        end
        else
        begin
            errs = 0;
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    if (paddr[2] == REG_HIGH)
                        high_thr = pwdata[VALUE_W-1:0];
                    else
                        mid_thr = pwdata[VALUE_W-1:0];
                end
                else
                begin
                    errs += check_field("prdata",
                        (paddr[2] == REG_HIGH) ? int'(high_thr) : int'(mid_thr),
                        int'($signed(prdata[VALUE_W-1:0])));
                end
            end
            if (s_tvalid && s_tready)
            begin
                run_values[loaded] = s_tdata;
                loaded++;
                if (loaded == ITEM_COUNT)
                begin
                    loaded = 0;
                    sort_and_count();
                end
            end
            if (m_tvalid && m_tready)
            begin
                if (ranked_q.size() == 0)
                begin
                    $error("result item with nothing expected: tdata %h tlast %b",
                           m_tdata, m_tlast);
                    errs++;
                end
                else
                begin
                    want = ranked_q.pop_front();
                    errs += check_field("sorted_value", int'($signed(want.value)),
                                        int'($signed(m_tdata[15:0])));
                    errs += check_field("rank", int'(want.rank), int'(m_tdata[19:16]));
                    errs += check_field("top_quarter_count", int'(want.top_quarter),
                                        int'(m_tdata[22:20]));
                    errs += check_field("band_count", int'($signed(want.band)),
                                        int'($signed(m_tdata[27:23])));
                    errs += check_field("tdata_pad", 0, int'(m_tdata[TDATA_W-1:OUT_W]));
                    errs += check_field("last_result", int'(want.last), int'(m_tlast));
                end
            end
            failures <= failures + errs;
            pending  <= ranked_q.size();
        end
    end

endmodule

FILE: verif/sort16_with_band_counts_core_tb.sv
// Testbench top for the sort-and-count block: stimulus, threshold phases and the verdict.
`timescale 1ns / 1ps
module sort16_with_band_counts_core_tb;
    import sbc_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASES        = 9;
    localparam logic [APB_ADDR_W-1:0] ADDR_HIGH = 3'd0;
    localparam logic [APB_ADDR_W-1:0] ADDR_MID  = 3'd4;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [VALUE_W-1:0]     s_tdata;    // [15:0] sample_value
    logic                   m_tvalid;
    logic                   m_tready;
    logic [TDATA_W-1:0]     m_tdata;    // [15:0] value, [19:16] rank, [22:20] quarter,
                                        // [27:23] band, [31:28] zero
    logic                   m_tlast;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    int                     failures;
    int                     pending;
    int                     burst_left;
    logic signed [VALUE_W-1:0] cur_high;
    logic signed [VALUE_W-1:0] cur_mid;

    logic [VALUE_W-1:0] directed_run [ITEM_COUNT] = '{
        16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'd1, 16'd85, 16'd84, 16'd86,
        16'd75, 16'd74, 16'd76, 16'h7fff, 16'h8000, 16'd85, 16'd75, 16'd100
    };

    sort16_with_band_counts_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    sort16_with_band_counts_checker sort_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .failures (failures),
        .pending  (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("sort16_with_band_counts_core_tb failed");
        $finish;
    end

    // The receiver switches between steady, random and periodic stall patterns.
    initial
    begin : receiver
        int mode;
        int len;
        int tick;
        m_tready = 1'b0;
        tick = 0;
        forever
        begin
            mode = $urandom_range(0, 3);
            len  = $urandom_range(5, 40);
            repeat (len)
            begin
                @(negedge clk);
                tick++;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= (tick % 3 == 0);
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Called at a falling edge; returns at a falling edge with the bus idle.
    task automatic reg_access(input bit is_write, input logic [APB_ADDR_W-1:0] addr,
                              input logic [VALUE_W-1:0] value);
        logic [15:0] upper;
        upper = 16'($urandom);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= addr;
        pwdata  <= {upper, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_thresholds(input logic [VALUE_W-1:0] high, input logic [VALUE_W-1:0] mid);
        reg_access(1'b1, ADDR_HIGH, high);
        reg_access(1'b1, ADDR_MID, mid);
        reg_access(1'b0, ADDR_HIGH, '0);
        reg_access(1'b0, ADDR_MID, '0);
        cur_high = high;
        cur_mid  = mid;
    endtask

    // Presents one item and waits for it to be taken; the sender runs in bursts.
    task automatic load_sample(input logic [VALUE_W-1:0] value);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                s_tdata  <= VALUE_W'($urandom);
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Mixes full-range values, values around either threshold and the extremes.
    function automatic logic [VALUE_W-1:0] pick_sample();
        case ($urandom_range(0, 4))
            0, 1:    return VALUE_W'($urandom);
            2:       return VALUE_W'(int'(cur_high) + int'($urandom_range(0, 6)) - 3);
            3:       return VALUE_W'(int'(cur_mid) + int'($urandom_range(0, 6)) - 3);
            default:
            begin
                case ($urandom_range(0, 3))
                    0:       return 16'h8000;
                    1:       return 16'h7fff;
                    2:       return 16'h0000;
                    default: return 16'hffff;
                endcase
            end
        endcase
    endfunction

    initial
    begin : stimulus
        logic [VALUE_W-1:0] high;
        logic [VALUE_W-1:0] mid;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        cur_high   = HIGH_RESET;
        cur_mid    = MID_RESET;
        burst_left = $urandom_range(1, 24);
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset thresholds read back, then one run of edge values and ties.
        reg_access(1'b0, ADDR_HIGH, '0);
        reg_access(1'b0, ADDR_MID, '0);
        foreach (directed_run[i])
            load_sample(directed_run[i]);
        wait_idle();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    // Inverted thresholds drive band_count negative.
                    high = 16'h8000;
                    mid  = 16'h7fff;
                end
                1:
                begin
                    high = 16'h7fff;
                    mid  = 16'h8000;
                end
                2:
                begin
                    high = 16'h0000;
                    mid  = 16'h0000;
                end
                3:
                begin
                    high = HIGH_RESET;
                    mid  = MID_RESET;
                end
                default:
                begin
                    high = VALUE_W'($urandom);
                    mid  = ($urandom_range(0, 1) == 0) ? VALUE_W'($urandom)
                         : VALUE_W'(int'($signed(high)) + int'($urandom_range(0, 200)) - 100);
                end
            endcase
            set_thresholds(high, mid);
            repeat (ITEM_COUNT) load_sample(pick_sample());
            wait_idle();
        end

        if (failures == 0)
            $display("sort16_with_band_counts_core_tb passed");
        else
            $display("sort16_with_band_counts_core_tb failed");
        $finish;
    end

endmodule

FILE: sort16_with_band_counts_core.f
src/sbc_pkg.sv
src/sbc_datapath.sv
src/sbc_ctrl.sv
src/sort16_with_band_counts_core.sv
src/sbc_checker.sv
verif/sort16_with_band_counts_checker.sv
verif/sort16_with_band_counts_core_tb.sv
